/* src/burst_envelope_smoother_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the burst envelope smoother
// Shared shorthand for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef BURST_ENVELOPE_SMOOTHER_CORE_ASSERT_SVH
`define BURST_ENVELOPE_SMOOTHER_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define BES_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define BES_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define BES_ASSERT_ALW(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bes_pkg.sv */
// ----------------------------------------------------------------------------
// Burst envelope smoother package
// Field widths, register reset values and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bes_pkg;

  localparam int BURST_LEN_DEFAULT = 32;

  localparam int SAMPLE_W = 32;
  localparam int LEVEL_W  = 31;
  localparam int SHIFT_W  = 3;
  localparam int CLIP_W   = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEVEL_W-1:0] USABLE_LIMIT_RESET = 31'd390000000;
  localparam logic [LEVEL_W-1:0] RAIL_LEVEL_RESET   = 31'd400000000;
  localparam logic [SHIFT_W-1:0] FILTER_SHIFT_RESET = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USABLE_LIMIT = 2'd0,
    CFG_RAIL_LEVEL   = 2'd1,
    CFG_FILTER_SHIFT = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

/* src/bes_accum.sv */
// ----------------------------------------------------------------------------
// Burst accumulator
// Registers each sample, rectifies and limits it, sums one burst and counts its clips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bes_accum #(
  parameter int BURST_LEN = bes_pkg::BURST_LEN_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [bes_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic [bes_pkg::LEVEL_W-1:0]   usable_limit,
  input  wire logic [bes_pkg::LEVEL_W-1:0]   rail_level,
  output logic                               burst_valid,
  input  wire logic                          burst_ready,
  output logic [bes_pkg::LEVEL_W+$clog2(BURST_LEN)-1:0] burst_sum,
  output logic [bes_pkg::CLIP_W-1:0]         burst_clips
);

  localparam int POS_W = $clog2(BURST_LEN);
  localparam int SUM_W = bes_pkg::LEVEL_W + POS_W;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BURST_LEN - 1);

  logic                            s_valid;
  logic [bes_pkg::SAMPLE_W-1:0]    s_sample;
  logic [POS_W-1:0]                pos;
  logic [SUM_W-1:0]                sum_acc;
  logic [bes_pkg::CLIP_W-1:0]      clips_acc;

  logic [bes_pkg::SAMPLE_W-1:0]    mag;
  logic                            clipped;
  logic [bes_pkg::LEVEL_W-1:0]     limited;
  logic [SUM_W-1:0]                sum_next;
  logic [bes_pkg::CLIP_W-1:0]      clips_next;
  logic                            last;
  logic                            b_free;
  logic                            s_move;
  logic                            accept;

  // The most negative sample negates to itself, which read unsigned is 2^31.
  always_comb begin
    mag        = s_sample[bes_pkg::SAMPLE_W-1] ? (~s_sample + 1'b1) : s_sample;
    clipped    = (mag >= {1'b0, rail_level});
    limited    = (mag > {1'b0, usable_limit}) ? usable_limit
                                               : mag[bes_pkg::LEVEL_W-1:0];
    sum_next   = sum_acc + SUM_W'(limited);
    clips_next = clips_acc + bes_pkg::CLIP_W'(clipped);
    last       = (pos == LAST_POS);
    b_free     = !burst_valid || burst_ready;
    s_move     = s_valid && (!last || b_free);
    in_stall   = s_valid && last && !b_free;
    accept     = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid     <= 1'b0;
      pos         <= '0;
      sum_acc     <= '0;
      clips_acc   <= '0;
      burst_valid <= 1'b0;
    end else begin
      if (accept) begin
        s_valid <= 1'b1;
      end else if (s_move) begin
        s_valid <= 1'b0;
      end

      if (s_move) begin
        if (last) begin
          pos       <= '0;
          sum_acc   <= '0;
          clips_acc <= '0;
        end else begin
          pos       <= POS_W'(pos + 1'b1);
          sum_acc   <= sum_next;
          clips_acc <= clips_next;
        end
      end

      if (s_move && last) begin
        burst_valid <= 1'b1;
      end else if (burst_ready) begin
        burst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_sample <= sample;
    end
    if (s_move && last) begin
      burst_sum   <= sum_next;
      burst_clips <= clips_next;
    end
  end

endmodule

`default_nettype wire

/* src/bes_recip_div.sv */
// ----------------------------------------------------------------------------
// Burst mean divider
// Divides a burst sum by the burst length through a reciprocal product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bes_recip_div #(
  parameter int BURST_LEN = bes_pkg::BURST_LEN_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bes_pkg::LEVEL_W+$clog2(BURST_LEN)-1:0] in_sum,
  input  wire logic [bes_pkg::CLIP_W-1:0]    in_clips,
  output logic                               env_valid,
  input  wire logic                          env_ready,
  output logic [bes_pkg::LEVEL_W-1:0]        env_level,
  output logic [bes_pkg::CLIP_W-1:0]         env_clips
);

  // With M = ceil(2^K / BURST_LEN) and K = sum width + log2 of the length,
  // the error term stays below 2^(K - sum width), so the quotient is exact
  // for every sum that fits the accumulator.
  localparam int DIV_L  = $clog2(BURST_LEN);
  localparam int SUM_W  = bes_pkg::LEVEL_W + DIV_L;
  localparam int DIV_K  = SUM_W + DIV_L;
  localparam int MUL_W  = SUM_W + 2;
  localparam logic [63:0] DIV_M64 =
    ((64'd1 << DIV_K) + 64'(BURST_LEN) - 64'd1) / 64'(BURST_LEN);
  localparam logic [MUL_W-1:0] DIV_M = DIV_M64[MUL_W-1:0];

  localparam int SL_W = (SUM_W + 1) / 2;
  localparam int SH_W = SUM_W - SL_W;
  localparam int ML_W = (MUL_W + 1) / 2;
  localparam int MH_W = MUL_W - ML_W;
  localparam int LL_W = SL_W + ML_W;
  localparam int LH_W = SL_W + MH_W;
  localparam int HL_W = SH_W + ML_W;
  localparam int HH_W = SH_W + MH_W;
  localparam int PROD_W = SUM_W + MUL_W;

  localparam logic [ML_W-1:0] M_LO = DIV_M[ML_W-1:0];
  localparam logic [MH_W-1:0] M_HI = DIV_M[MUL_W-1:ML_W];

  logic                       p_valid;
  logic [LL_W-1:0]            pp_ll;
  logic [LH_W-1:0]            pp_lh;
  logic [HL_W-1:0]            pp_hl;
  logic [HH_W-1:0]            pp_hh;
  logic [bes_pkg::CLIP_W-1:0] p_clips;
  logic                       p_ready;
  logic [PROD_W-1:0]          prod;

  always_comb begin
    p_ready  = !env_valid || env_ready;
    in_ready = !p_valid || p_ready;
    prod = PROD_W'(pp_ll)
         + (PROD_W'(pp_lh) << ML_W)
         + (PROD_W'(pp_hl) << SL_W)
         + (PROD_W'(pp_hh) << (SL_W + ML_W));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      env_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        p_valid <= in_valid;
      end
      if (p_ready) begin
        env_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pp_ll   <= LL_W'(in_sum[SL_W-1:0]) * LL_W'(M_LO);
      pp_lh   <= LH_W'(in_sum[SL_W-1:0]) * LH_W'(M_HI);
      pp_hl   <= HL_W'(in_sum[SUM_W-1:SL_W]) * HL_W'(M_LO);
      pp_hh   <= HH_W'(in_sum[SUM_W-1:SL_W]) * HH_W'(M_HI);
      p_clips <= in_clips;
    end
    if (p_ready && p_valid) begin
      env_level <= prod[DIV_K +: bes_pkg::LEVEL_W];
      env_clips <= p_clips;
    end
  end

endmodule

`default_nettype wire

/* src/burst_envelope_smoother_core.sv */
// ----------------------------------------------------------------------------
// Burst envelope smoother
// Rectified burst average followed by an exponential smoothing filter.
// ----------------------------------------------------------------------------
// The block takes one sample per clock cycle while not stalled and gives one
// result for every BURST_LEN samples: the filtered level, the burst mean and
// the count of clipped samples. A result passes these registers in order: the
// input register takes the last sample of its burst at the accepting edge,
// then the burst accumulator, the partial-product stage and the summing
// stage of the reciprocal divider are loaded, and the filter loads the
// output register. The sample input stalls only when a finished burst cannot
// move into the divider, which happens only after the result side has held
// its stall long enough to fill the pipeline. Registers are to be written
// only while no transaction is in flight; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module burst_envelope_smoother_core #(
  parameter int BURST_LEN = bes_pkg::BURST_LEN_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [bes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bes_pkg::LEVEL_W-1:0]    cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [bes_pkg::SAMPLE_W-1:0]   sample,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [bes_pkg::LEVEL_W-1:0]         filtered_level,
  output logic [bes_pkg::LEVEL_W-1:0]         envelope_level,
  output logic [bes_pkg::CLIP_W-1:0]          clipped_count
);

  localparam int SUM_W  = bes_pkg::LEVEL_W + $clog2(BURST_LEN);
  localparam int DIFF_W = bes_pkg::LEVEL_W + 2;

  logic [bes_pkg::LEVEL_W-1:0] usable_limit;
  logic [bes_pkg::LEVEL_W-1:0] rail_level;
  logic [bes_pkg::SHIFT_W-1:0] filter_shift;

  logic                        burst_valid;
  logic                        burst_ready;
  logic [SUM_W-1:0]            burst_sum;
  logic [bes_pkg::CLIP_W-1:0]  burst_clips;

  logic                        env_valid;
  logic                        env_ready;
  logic [bes_pkg::LEVEL_W-1:0] env_level;
  logic [bes_pkg::CLIP_W-1:0]  env_clips;

  logic [bes_pkg::LEVEL_W-1:0] smoothed;
  logic                        smoothed_loaded;
  logic [bes_pkg::LEVEL_W-1:0] smoothed_next;
  logic [DIFF_W-1:0]           diff;
  logic [DIFF_W-1:0]           bias;
  logic [DIFF_W-1:0]           step;
  logic [DIFF_W-1:0]           moved;
  logic                        load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      usable_limit <= bes_pkg::USABLE_LIMIT_RESET;
      rail_level   <= bes_pkg::RAIL_LEVEL_RESET;
      filter_shift <= bes_pkg::FILTER_SHIFT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bes_pkg::CFG_USABLE_LIMIT: usable_limit <= cfg_data;
        bes_pkg::CFG_RAIL_LEVEL:   rail_level   <= cfg_data;
        bes_pkg::CFG_FILTER_SHIFT: filter_shift <= cfg_data[bes_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  bes_accum #(
    .BURST_LEN(BURST_LEN)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .usable_limit (usable_limit),
    .rail_level   (rail_level),
    .burst_valid  (burst_valid),
    .burst_ready  (burst_ready),
    .burst_sum    (burst_sum),
    .burst_clips  (burst_clips)
  );

  bes_recip_div #(
    .BURST_LEN(BURST_LEN)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (burst_valid),
    .in_ready  (burst_ready),
    .in_sum    (burst_sum),
    .in_clips  (burst_clips),
    .env_valid (env_valid),
    .env_ready (env_ready),
    .env_level (env_level),
    .env_clips (env_clips)
  );

  // The filter step truncates toward zero, so a negative difference is
  // biased up by one less than the divisor before the arithmetic shift.
  always_comb begin
    env_ready = !out_valid || !out_stall;
    load_out  = env_valid && env_ready;
    diff      = {2'b00, env_level} - {2'b00, smoothed};
    bias      = diff[DIFF_W-1] ? ((DIFF_W'(1) << filter_shift) - DIFF_W'(1)) : '0;
    step      = DIFF_W'($signed(diff + bias) >>> filter_shift);
    moved     = {2'b00, smoothed} + step;
    smoothed_next = smoothed_loaded ? moved[bes_pkg::LEVEL_W-1:0] : env_level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      smoothed        <= '0;
      smoothed_loaded <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid       <= 1'b1;
        smoothed        <= smoothed_next;
        smoothed_loaded <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      filtered_level <= smoothed_next;
      envelope_level <= env_level;
      clipped_count  <= env_clips;
    end
  end

endmodule

`default_nettype wire

/* src/bes_port_checker.sv */
// ----------------------------------------------------------------------------
// Burst envelope smoother port checker
// Concurrent checks on the top level's ports, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "burst_envelope_smoother_core_assert.svh"

module bes_port_checker #(
  parameter int BURST_LEN = bes_pkg::BURST_LEN_DEFAULT
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [bes_pkg::LEVEL_W-1:0]   filtered_level,
  input wire logic [bes_pkg::LEVEL_W-1:0]   envelope_level,
  input wire logic [bes_pkg::CLIP_W-1:0]    clipped_count
);

  // Above 63 the count wraps, so any code of the field is possible.
  localparam logic [bes_pkg::CLIP_W:0] CLIP_MAX =
    (BURST_LEN > 63) ? 7'd63 : 7'(BURST_LEN);

  // The sample side can only back up once a result is held on the output.
  `BES_ASSERT_IMP(a_stall_needs_held_result, clk, rst, in_stall,
    out_valid && out_stall, "sample stall without a held result")

  `BES_ASSERT_NXT(a_held_result_stable, clk, rst, out_valid && out_stall,
    out_valid && $stable(filtered_level) && $stable(envelope_level)
      && $stable(clipped_count), "held result changed")

  `BES_ASSERT_IMP(a_clip_count_range, clk, rst, out_valid,
    {1'b0, clipped_count} <= CLIP_MAX, "clip count exceeds the burst length")

  `BES_ASSERT_ALW(a_reset_clears, clk, rst, !out_valid && !in_stall,
    "pipeline not empty after reset")

endmodule

bind burst_envelope_smoother_core bes_port_checker #(
  .BURST_LEN(BURST_LEN)
) u_bes_port_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .filtered_level (filtered_level),
  .envelope_level (envelope_level),
  .clipped_count  (clipped_count)
);

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Burst envelope smoother testbench
// Feeds signed samples under random input gaps and result stalls. A
// scoreboard keeps its own copy of the burst accumulator and smoothing
// filter, and checks every result field against the oldest expected burst.
// Register settings change between phases, and the extremes are included.
// ----------------------------------------------------------------------------

import bes_pkg::*;

typedef struct packed {
  logic [LEVEL_W-1:0] filtered;
  logic [LEVEL_W-1:0] envelope;
  logic [CLIP_W-1:0]  clipped;
} burst_result_t;

class envelope_scoreboard;
  int burst_len;
  logic [LEVEL_W-1:0] usable_limit;
  logic [LEVEL_W-1:0] rail_level;
  logic [SHIFT_W-1:0] filter_shift;
  int                 position;
  logic [36:0]        burst_sum;
  int                 clip_tally;
  logic [LEVEL_W-1:0] smoothed;
  bit                 loaded;
  burst_result_t      expected_bursts[$];
  int                 errors;

  function new(int len);
    burst_len    = len;
    usable_limit = USABLE_LIMIT_RESET;
    rail_level   = RAIL_LEVEL_RESET;
    filter_shift = FILTER_SHIFT_RESET;
    position     = 0;
    burst_sum    = '0;
    clip_tally   = 0;
    smoothed     = '0;
    loaded       = 1'b0;
    errors       = 0;
  endfunction

  // An index outside the register map is dropped by the block.
  function void write_reg(logic [CFG_IDX_W-1:0] index, logic [LEVEL_W-1:0] data);
    case (index)
      CFG_USABLE_LIMIT: usable_limit = data;
      CFG_RAIL_LEVEL:   rail_level = data;
      CFG_FILTER_SHIFT: filter_shift = data[SHIFT_W-1:0];
      default: ;
    endcase
  endfunction

  function void note_sample(logic [SAMPLE_W-1:0] s);
    logic [32:0]        mag;
    logic [LEVEL_W-1:0] limited;
    logic [LEVEL_W-1:0] envelope;
    longint             diff;
    longint             delta;
    burst_result_t      res;
    // Widening to 33 bits keeps the magnitude of the most negative sample.
    mag = s[31] ? ({1'b0, ~s} + 33'd1) : {1'b0, s};
    if (mag >= {2'b00, rail_level}) clip_tally++;
    limited = (mag > {2'b00, usable_limit}) ? usable_limit : mag[LEVEL_W-1:0];
    burst_sum += {6'b0, limited};
    position++;
    if (position < burst_len) return;
    envelope = LEVEL_W'(burst_sum / burst_len);
    if (!loaded) begin
      smoothed = envelope;
      loaded = 1'b1;
    end else begin
      diff = longint'(envelope) - longint'(smoothed);
      delta = diff / (longint'(1) << filter_shift);
      smoothed = LEVEL_W'(longint'(smoothed) + delta);
    end
    res.filtered = smoothed;
    res.envelope = envelope;
    res.clipped = CLIP_W'(clip_tally);
    expected_bursts.push_back(res);
    position = 0;
    burst_sum = '0;
    clip_tally = 0;
  endfunction

  function void check_result(logic [LEVEL_W-1:0] filtered, logic [LEVEL_W-1:0] envelope,
                             logic [CLIP_W-1:0] clipped);
    burst_result_t want;
    if (expected_bursts.size() == 0) begin
      $error("unexpected result: filtered_level %0d envelope_level %0d clipped_count %0d",
             filtered, envelope, clipped);
      errors++;
      return;
    end
    want = expected_bursts.pop_front();
    if (filtered !== want.filtered) begin
      $error("filtered_level mismatch: expected %0d, actual %0d", want.filtered, filtered);
      errors++;
    end
    if (envelope !== want.envelope) begin
      $error("envelope_level mismatch: expected %0d, actual %0d", want.envelope, envelope);
      errors++;
    end
    if (clipped !== want.clipped) begin
      $error("clipped_count mismatch: expected %0d, actual %0d", want.clipped, clipped);
      errors++;
    end
  endfunction

  function int pending();
    return expected_bursts.size();
  endfunction
endclass

module testbench;

  localparam int BURST = BURST_LEN_DEFAULT;
  localparam int TARGET_SAMPLES = 1650;
  localparam int SETTLE_CYCLES = 12;
  localparam int IDLE_LIMIT = 5000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 31'h7FFFFFFF;

  typedef enum {STYLE_MIXED, STYLE_LOUD} phase_style_t;

  localparam logic [SAMPLE_W-1:0] DIRECTED [16] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'd400000000, 32'd399999999, -32'd400000000, -32'd399999999, 32'd390000000,
    32'd390000001, -32'd390000000, -32'd390000001, 32'd400000001, 32'h8000_0001,
    32'h7FFF_FFFE
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEVEL_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [SAMPLE_W-1:0] sample;
  logic out_valid;
  logic out_stall;
  logic [LEVEL_W-1:0] filtered_level;
  logic [LEVEL_W-1:0] envelope_level;
  logic [CLIP_W-1:0] clipped_count;

  envelope_scoreboard sb = new(BURST);
  int idle_cycles = 0;
  bit gaps_off;

  burst_envelope_smoother_core #(.BURST_LEN(BURST)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .filtered_level(filtered_level),
    .envelope_level(envelope_level),
    .clipped_count(clipped_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(filtered_level, envelope_level, clipped_count);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Mostly short gaps, a few long ones.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [LEVEL_W-1:0] random_level();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return LEVEL_MAX;
      2: return LEVEL_W'($urandom);
      3: return LEVEL_W'($urandom_range(0, 1000));
      default: return LEVEL_W'($urandom_range(300000000, 500000000));
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample(phase_style_t style);
    logic [SAMPLE_W-1:0] mag;
    if (style == STYLE_LOUD) begin
      if ($urandom_range(0, 1)) return 32'h7FFF_FFFF - $urandom_range(0, 3);
      return 32'h8000_0000 + $urandom_range(0, 3);
    end
    case ($urandom_range(0, 9))
      0: return $urandom;
      1, 2: mag = {1'b0, sb.rail_level} + $urandom_range(0, 4) - 2;
      3, 4: mag = {1'b0, sb.usable_limit} + $urandom_range(0, 4) - 2;
      5: begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h8000_0000;
          3: return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: mag = $urandom_range(0, 32'h3FFF_FFFF);
    endcase
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic push_sample(logic [SAMPLE_W-1:0] s);
    int gap;
    in_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (in_stall);
    sb.note_sample(s);
    gap = gaps_off ? 0 : gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [LEVEL_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(index, data);
  endtask

  // A partial burst leaves no result to wait for, so allow the pipeline to empty too.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int n;
    out_stall <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      n = ($urandom_range(0, 99) < 92) ? $urandom_range(0, 3) : $urandom_range(30, 150);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      n = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 8) : $urandom_range(50, 300);
      repeat (n) @(posedge clk);
    end
  end

  initial begin
    int total;
    int phase;
    int count;
    phase_style_t style;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_USABLE_LIMIT;
    cfg_data <= '0;
    in_valid <= 1'b0;
    sample <= '0;
    gaps_off = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Boundary samples at reset settings; the first burst loads the filter.
    foreach (DIRECTED[i]) push_sample(DIRECTED[i]);
    total = $size(DIRECTED);
    for (int i = 0; i < 3 * BURST - 5; i++) push_sample(random_sample(STYLE_MIXED));
    total += 3 * BURST - 5;
    settle_block();

    phase = 0;
    while (total < TARGET_SAMPLES) begin
      style = STYLE_MIXED;
      case (phase)
        0: begin
          write_register(CFG_USABLE_LIMIT, LEVEL_MAX);
          write_register(CFG_RAIL_LEVEL, LEVEL_MAX);
          write_register(CFG_FILTER_SHIFT, LEVEL_W'(0));
          style = STYLE_LOUD;
        end
        1: begin
          write_register(CFG_USABLE_LIMIT, '0);
          write_register(CFG_RAIL_LEVEL, '0);
          write_register(CFG_FILTER_SHIFT, LEVEL_W'(7));
        end
        2: begin
          write_register(CFG_UNUSED_INDEX, LEVEL_W'($urandom));
          write_register(CFG_USABLE_LIMIT, LEVEL_MAX);
          write_register(CFG_RAIL_LEVEL, LEVEL_W'(1));
        end
        3: begin
          write_register(CFG_FILTER_SHIFT, LEVEL_W'(7));
          style = STYLE_LOUD;
        end
        default: begin
          if ($urandom_range(0, 2) != 0) write_register(CFG_USABLE_LIMIT, random_level());
          if ($urandom_range(0, 2) != 0) write_register(CFG_RAIL_LEVEL, random_level());
          if ($urandom_range(0, 1) != 0)
            write_register(CFG_FILTER_SHIFT, LEVEL_W'($urandom_range(0, 7)));
          if ($urandom_range(0, 7) == 0) write_register(CFG_UNUSED_INDEX, random_level());
          if ($urandom_range(0, 5) == 0) style = STYLE_LOUD;
        end
      endcase
      cfg_we <= 1'b0;
      gaps_off = ($urandom_range(0, 4) == 0);
      count = $urandom_range(40, 220);
      for (int i = 0; i < count; i++) push_sample(random_sample(style));
      total += count;
      phase++;
      settle_block();
    end

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/bes_pkg.sv
src/bes_accum.sv
src/bes_recip_div.sv
src/burst_envelope_smoother_core.sv
src/bes_port_checker.sv
verif/testbench.sv
